// ----- rtl/core/text_console_cursor_engine_unit_macros.svh -----
// Assertion macros for the text console cursor engine.
// Each use stands on a line of its own and gives a label, the clock, the
// active-low reset, the antecedent, the consequent and the message.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH

// Consequent in the same cycle.
`define CCE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the next cycle.
`define CCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor engine package
// Types, operation and command codes shared by the cursor engine modules.
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam int DEF_SCREEN_ROWS = 25;
    localparam int DEF_SCREEN_COLS = 40;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int ROW_W = 5;
    localparam int COL_W = 6;

    // Operation codes
    localparam logic [3:0] FUNC_WRITE    = 4'd0;
    localparam logic [3:0] FUNC_UP       = 4'd1;
    localparam logic [3:0] FUNC_DOWN     = 4'd2;
    localparam logic [3:0] FUNC_LEFT     = 4'd3;
    localparam logic [3:0] FUNC_RIGHT    = 4'd4;
    localparam logic [3:0] FUNC_SETPOS   = 4'd5;
    localparam logic [3:0] FUNC_CLEARROW = 4'd6;
    localparam logic [3:0] FUNC_ON       = 4'd7;
    localparam logic [3:0] FUNC_OFF      = 4'd8;
    localparam logic [3:0] FUNC_HOME     = 4'd9;

    // Display command codes
    localparam logic [1:0] CMD_PUT      = 2'd0;
    localparam logic [1:0] CMD_SCROLL   = 2'd1;
    localparam logic [1:0] CMD_SETFLASH = 2'd2;
    localparam logic [1:0] CMD_CLRFLASH = 2'd3;

    // Control characters
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT_CR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT_LF = 1'b1;

    // A job holds up to five single commands plus an optional row fill
    localparam int JOB_SLOTS  = 5;
    localparam int SLOT_IDX_W = $clog2(JOB_SLOTS + 1);

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] char_code;
        logic [5:0] row_arg;
        logic [5:0] col_arg;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ROW_W-1:0] cmd_row;
        logic [COL_W-1:0] cmd_col;
        logic [7:0]       cmd_char;
        logic [ROW_W-1:0] cursor_row_now;
        logic [COL_W-1:0] cursor_col_now;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       chr;
    } t_slot;

    typedef struct packed {
        t_slot [JOB_SLOTS-1:0] slots;
        logic [SLOT_IDX_W-1:0] n;
        logic                  fill;
        logic                  fill_pos;
        logic [ROW_W-1:0]      fill_row;
        logic [ROW_W-1:0]      fin_row;
        logic [COL_W-1:0]      fin_col;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/core/cce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor engine front end
// Accepts operations, updates the cursor and builds the command job.
// ----------------------------------------------------------------------------
module cce_front #(
    parameter int SCREEN_ROWS = cce_pkg::DEF_SCREEN_ROWS,
    parameter int SCREEN_COLS = cce_pkg::DEF_SCREEN_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cce_pkg::t_in_item                i_in_data,
    input  logic                             i_cfg_we,
    input  logic [cce_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic                             i_cfg_data,
    input  cce_pkg::t_q_stat                 i_q_stat,
    output logic                             o_push,
    output cce_pkg::t_job                    o_job
);
    import cce_pkg::*;

    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int CW = $clog2(SCREEN_COLS);
    localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic          r_shown, n_shown;
    logic          r_icr;
    logic          r_ilf;

    logic                  accept;
    t_job                  job;
    logic [SLOT_IDX_W-1:0] k;

    function automatic t_slot mk(input logic [1:0] c, input logic [RW-1:0] r,
                                 input logic [CW-1:0] cl, input logic [7:0] ch);
        t_slot s;
        s.cmd = c;
        s.row = ROW_W'(r);
        s.col = COL_W'(cl);
        s.chr = ch;
        return s;
    endfunction

    assign accept     = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_shown = r_shown;
        job     = '0;
        k       = '0;
        unique case (i_in_data.func)
            FUNC_WRITE: begin
                priority if (i_in_data.char_code == CH_BS) begin
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    if (n_col != '0) n_col = n_col - 1'b1;
                    job.slots[k] = mk(CMD_PUT, n_row, n_col, CH_SPACE);
                    k = k + 1'b1;
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                end else if (i_in_data.char_code == CH_CR) begin
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    n_col = '0;
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    if (r_ilf) begin
                        if (n_shown) begin
                            job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                            k = k + 1'b1;
                        end
                        if (n_row == LAST_ROW) begin
                            job.slots[k] = mk(CMD_SCROLL, '0, '0, CH_NONE);
                            k = k + 1'b1;
                        end else begin
                            n_row = n_row + 1'b1;
                        end
                        if (n_shown) begin
                            job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                            k = k + 1'b1;
                        end
                    end
                end else if (i_in_data.char_code == CH_LF) begin
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    if (n_row == LAST_ROW) begin
                        job.slots[k] = mk(CMD_SCROLL, '0, '0, CH_NONE);
                        k = k + 1'b1;
                    end else begin
                        n_row = n_row + 1'b1;
                    end
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    if (r_icr) begin
                        if (n_shown) begin
                            job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                            k = k + 1'b1;
                        end
                        n_col = '0;
                        if (n_shown) begin
                            job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                            k = k + 1'b1;
                        end
                    end
                end else begin
                    job.slots[k] = mk(CMD_PUT, n_row, n_col, i_in_data.char_code);
                    k = k + 1'b1;
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    if (n_col == LAST_COL) begin
                        n_col = '0;
                        if (n_row == LAST_ROW) begin
                            job.slots[k] = mk(CMD_SCROLL, '0, '0, CH_NONE);
                            k = k + 1'b1;
                        end else begin
                            n_row = n_row + 1'b1;
                        end
                    end else begin
                        n_col = n_col + 1'b1;
                    end
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                end
            end
            FUNC_UP, FUNC_DOWN, FUNC_LEFT, FUNC_RIGHT: begin
                if ((i_in_data.func == FUNC_UP    && r_row != '0) ||
                    (i_in_data.func == FUNC_DOWN  && r_row != LAST_ROW) ||
                    (i_in_data.func == FUNC_LEFT  && r_col != '0) ||
                    (i_in_data.func == FUNC_RIGHT && r_col != LAST_COL)) begin
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                    priority if (i_in_data.func == FUNC_UP)   n_row = n_row - 1'b1;
                    else if (i_in_data.func == FUNC_DOWN)     n_row = n_row + 1'b1;
                    else if (i_in_data.func == FUNC_LEFT)     n_col = n_col - 1'b1;
                    else                                       n_col = n_col + 1'b1;
                    if (n_shown) begin
                        job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                        k = k + 1'b1;
                    end
                end
            end
            FUNC_SETPOS: begin
                if (n_shown) begin
                    job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                    k = k + 1'b1;
                end
                // Saturate each coordinate to the screen
                n_row = ({1'b0, i_in_data.row_arg} < 7'(SCREEN_ROWS)) ?
                        RW'(i_in_data.row_arg) : LAST_ROW;
                n_col = ({1'b0, i_in_data.col_arg} < 7'(SCREEN_COLS)) ?
                        CW'(i_in_data.col_arg) : LAST_COL;
                if (n_shown) begin
                    job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                    k = k + 1'b1;
                end
            end
            FUNC_CLEARROW: begin
                if (n_shown) begin
                    job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                    k = k + 1'b1;
                end
                // The row fill runs in the back end ahead of slot fill_pos
                job.fill     = 1'b1;
                job.fill_pos = k[0];
                job.fill_row = ROW_W'(n_row);
                n_shown      = 1'b1;
                job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                k = k + 1'b1;
            end
            FUNC_ON: begin
                n_shown      = 1'b1;
                job.slots[k] = mk(CMD_SETFLASH, n_row, n_col, CH_NONE);
                k = k + 1'b1;
            end
            FUNC_OFF: begin
                if (n_shown) begin
                    job.slots[k] = mk(CMD_CLRFLASH, n_row, n_col, CH_NONE);
                    k = k + 1'b1;
                end
                n_shown = 1'b0;
            end
            FUNC_HOME: begin
                n_row = '0;
                n_col = '0;
            end
            default: begin
                // Unknown operation: drop
            end
        endcase
        job.n       = k;
        job.fin_row = ROW_W'(n_row);
        job.fin_col = COL_W'(n_col);
    end

    assign o_push = accept && (k != '0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_shown <= 1'b1;
            r_icr   <= 1'b1;
            r_ilf   <= 1'b1;
        end else begin
            if (accept) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_shown <= n_shown;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMPLICIT_CR) r_icr <= i_cfg_data;
                else                              r_ilf <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/core/cce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor engine job queue
// Short first-in first-out store of jobs between front and back end.
// ----------------------------------------------------------------------------
module cce_queue #(
    parameter int QUEUE_DEPTH = cce_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cce_pkg::t_job    i_job,
    input  logic             i_pop,
    output cce_pkg::t_job    o_job,
    output cce_pkg::t_q_stat o_stat
);
    import cce_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rp];
    assign n_wp         = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
    assign n_rp         = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= n_wp;
            if (do_pop)  r_rp <= n_rp;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- rtl/core/cce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor engine back end
// Expands each job into display command beats, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module cce_back #(
    parameter int SCREEN_COLS = cce_pkg::DEF_SCREEN_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cce_pkg::t_q_stat   i_q_stat,
    input  cce_pkg::t_job      i_q_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cce_pkg::t_out_item o_out_data
);
    import cce_pkg::*;

    localparam int CW = $clog2(SCREEN_COLS);
    localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

    logic                  r_busy;
    t_job                  r_job;
    logic [SLOT_IDX_W-1:0] r_idx;
    logic                  r_fill_done;
    logic [CW-1:0]         r_fcol;
    logic                  r_oval;
    t_out_item             r_out;

    logic      adv;
    logic      emit;
    logic      cur_fill;
    logic      is_last;
    t_slot     sl;
    t_out_item beat;

    assign adv      = !r_oval || !i_out_stall;
    assign emit     = r_busy && adv;
    assign cur_fill = r_job.fill && !r_fill_done &&
                      (r_idx == SLOT_IDX_W'(r_job.fill_pos));
    assign sl       = r_job.slots[r_idx];
    // The fill always has a slot after it, so the final beat is a slot
    assign is_last  = !cur_fill && (r_idx == r_job.n - 1'b1);
    assign o_pop    = (!r_busy || (emit && is_last)) && !i_q_stat.empty;

    always_comb begin
        beat.cursor_row_now = r_job.fin_row;
        beat.cursor_col_now = r_job.fin_col;
        beat.last           = is_last;
        if (cur_fill) begin
            beat.cmd      = CMD_PUT;
            beat.cmd_row  = r_job.fill_row;
            beat.cmd_col  = COL_W'(r_fcol);
            beat.cmd_char = CH_SPACE;
        end else begin
            beat.cmd      = sl.cmd;
            beat.cmd_row  = sl.row;
            beat.cmd_col  = sl.col;
            beat.cmd_char = sl.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_oval      <= 1'b0;
            r_idx       <= '0;
            r_fill_done <= 1'b0;
            r_fcol      <= '0;
        end else begin
            if (emit)             r_oval <= 1'b1;
            else if (!i_out_stall) r_oval <= 1'b0;

            // Load the next job straight behind the final beat
            if (o_pop) begin
                r_busy      <= 1'b1;
                r_idx       <= '0;
                r_fill_done <= 1'b0;
                r_fcol      <= '0;
            end else if (emit) begin
                if (cur_fill) begin
                    if (r_fcol == LAST_COL) r_fill_done <= 1'b1;
                    else                    r_fcol <= r_fcol + 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
                if (is_last) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_q_job;
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/text_console_cursor_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine
// Tracks the cursor and turns console operations into display commands.
//
//   Channel   Direction  Handshake                       Beat
//   in        input      i_in_valid / o_in_stall         one operation
//   out       output     o_out_valid / i_out_stall       one display command
//   cfg       input      i_cfg_we (write only)           one register
//
// The front end takes one operation per cycle while the job queue has room;
// the back end sends one command per cycle while the output is not stalled.
// An operation with commands yields 1 to 5 of them (SCREEN_COLS + 1 or
// SCREEN_COLS + 2 for a row clear); one without commands pushes no job.
// With the back end idle an operation passes through the job queue, the
// back end job register and the output register before its first command
// appears. Reset is synchronous; no clearing pass. Output stall holds the
// output register and, once the queue fills, stalls the input.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_unit_macros.svh"

module text_console_cursor_engine_unit #(
    parameter int SCREEN_ROWS = cce_pkg::DEF_SCREEN_ROWS,
    parameter int SCREEN_COLS = cce_pkg::DEF_SCREEN_COLS,
    parameter int QUEUE_DEPTH = cce_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cce_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cce_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [cce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                          i_cfg_data
);
    import cce_pkg::*;

    logic    q_push;
    logic    q_pop;
    t_job    q_in_job;
    t_job    q_out_job;
    t_q_stat q_stat;

    cce_front #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_job      (q_in_job)
    );

    cce_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_stat  (q_stat)
    );

    cce_back #(
        .SCREEN_COLS (SCREEN_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_job     (q_out_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `CCE_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, q_push, !q_stat.full, "job pushed into full queue")
    `CCE_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, q_push && q_stat.empty && !q_pop, !q_stat.empty, "pushed job lost")
    `CCE_ASSERT_SAME(a_final_flash, i_clk, i_rst_n, o_out_valid && o_out_data.last && (o_out_data.cmd == CMD_SETFLASH), (o_out_data.cmd_row == o_out_data.cursor_row_now) && (o_out_data.cmd_col == o_out_data.cursor_col_now), "final flash not at cursor")

endmodule
